// ===== rtl/core/c2p_pkg.sv =====
// Shared types, constants and the arctangent table for the polar converter.
`default_nettype none
package c2p_pkg;

  localparam int unsigned DATA_WIDTH_DEF    = 24;
  localparam int unsigned PHASE_WIDTH_DEF   = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned MAX_STAGES        = 24;

  // x/y carry 32 bits of scaled input plus growth headroom
  localparam int unsigned XW       = 35;
  // angle accumulator, 30 fraction bits
  localparam int unsigned ZW       = 34;
  localparam int unsigned ANG_FRAC = 30;

  localparam int unsigned GAIN_W = 30;
  localparam int unsigned SPLIT  = 17;

  localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } c2p_vec_t;

  function automatic logic signed [ZW-1:0] c2p_atan(input int unsigned idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      0:       a = 34'sd843314857;
      1:       a = 34'sd497837829;
      2:       a = 34'sd263043837;
      3:       a = 34'sd133525159;
      4:       a = 34'sd67021687;
      5:       a = 34'sd33543516;
      6:       a = 34'sd16775851;
      7:       a = 34'sd8388437;
      8:       a = 34'sd4194283;
      9:       a = 34'sd2097149;
      10:      a = 34'sd1048576;
      11:      a = 34'sd524288;
      12:      a = 34'sd262144;
      13:      a = 34'sd131072;
      14:      a = 34'sd65536;
      15:      a = 34'sd32768;
      16:      a = 34'sd16384;
      17:      a = 34'sd8192;
      18:      a = 34'sd4096;
      19:      a = 34'sd2048;
      20:      a = 34'sd1024;
      21:      a = 34'sd512;
      22:      a = 34'sd256;
      23:      a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/c2p_fold.sv =====
// Input cell: scales the coefficient and folds it into the right half plane.
`default_nettype none
module c2p_fold import c2p_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic signed [DATA_WIDTH-1:0] real_part_i,
  input  wire logic signed [DATA_WIDTH-1:0] imag_part_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output c2p_vec_t                          vec_o
);

  localparam int unsigned GUARD = 32 - DATA_WIDTH;

  logic                 valid_q;
  logic                 en;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  c2p_vec_t             vec_d;
  c2p_vec_t             vec_q;

  assign x0 = XW'(real_part_i) <<< GUARD;
  assign y0 = XW'(imag_part_i) <<< GUARD;

  always_comb begin
    vec_d.zero = (real_part_i == '0) && (imag_part_i == '0);
    vec_d.x    = x0;
    vec_d.y    = y0;
    vec_d.z    = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        vec_d.x = y0;
        vec_d.y = -x0;
        vec_d.z = HALF_PI_Q30;
      end else begin
        vec_d.x = -y0;
        vec_d.y = x0;
        vec_d.z = -HALF_PI_Q30;
      end
    end
  end

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign vec_o   = vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      vec_q <= vec_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/c2p_cell.sv =====
// One CORDIC vectoring micro-rotation cell with its own handshake register.
`default_nettype none
module c2p_cell import c2p_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire c2p_vec_t vec_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output c2p_vec_t      vec_o
);

  localparam logic signed [ZW-1:0] ANGLE = c2p_atan(SHIFT);

  logic                 valid_q;
  logic                 en;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  c2p_vec_t             vec_d;
  c2p_vec_t             vec_q;

  assign dx = vec_i.y >>> SHIFT;
  assign dy = vec_i.x >>> SHIFT;

  always_comb begin
    vec_d.zero = vec_i.zero;
    if (vec_i.y >= 0) begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + ANGLE;
    end else begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - ANGLE;
    end
  end

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign vec_o   = vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      vec_q <= vec_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/c2p_scale.sv =====
// Output cells: gain correction in two stages and phase rounding with clamp.
`default_nettype none
module c2p_scale import c2p_pkg::*; #(
  parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int unsigned PHASE_WIDTH = PHASE_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire c2p_vec_t                 vec_i,
  output logic                          valid_o,
  input  wire logic                     ready_i,
  output logic [DATA_WIDTH-1:0]         magnitude_o,
  output logic signed [PHASE_WIDTH-1:0] phase_o
);

  localparam int unsigned GUARD = 32 - DATA_WIDTH;
  localparam int unsigned MSH   = ANG_FRAC + GUARD;
  localparam int unsigned PS    = ANG_FRAC - (PHASE_WIDTH - 3);
  localparam int unsigned XU    = XW - 1;
  localparam int unsigned HW    = XU - SPLIT;
  localparam int unsigned LPW   = SPLIT + GAIN_W;
  localparam int unsigned HPW   = HW + GAIN_W;
  localparam int unsigned SW    = XU + GAIN_W + 1;

  localparam logic signed [ZW:0] PRND  = (ZW+1)'(64'd1 << (PS - 1));
  localparam logic signed [ZW:0] PHMAX =
    (ZW+1)'((PI_Q30 + (64'd1 << (PS - 1))) >> PS);
  localparam logic [SW-1:0] MRND   = SW'(1) << (MSH - 1);
  localparam logic [SW-1:0] MAGMAX = SW'({DATA_WIDTH{1'b1}});

  // stage A: partial products and phase
  logic                          va_q;
  logic                          en_a;
  logic [XU-1:0]                 xc;
  logic signed [ZW:0]            zr;
  logic signed [ZW:0]            ph;
  logic signed [ZW:0]            ph_sat;
  logic [LPW-1:0]                plo_q;
  logic [HPW-1:0]                phi_q;
  logic signed [PHASE_WIDTH-1:0] pha_q;
  logic                          zero_a_q;

  // stage B: sum, round, saturate
  logic                          vb_q;
  logic                          en_b;
  logic [SW-1:0]                 sum;
  logic [SW-1:0]                 mag_full;
  logic [DATA_WIDTH-1:0]         mag_q;
  logic signed [PHASE_WIDTH-1:0] phb_q;

  assign xc = vec_i.x[XW-1] ? '0 : vec_i.x[XU-1:0];

  always_comb begin
    zr     = (ZW+1)'(vec_i.z) + PRND;
    ph     = zr >>> PS;
    ph_sat = ph;
    if (ph > PHMAX) begin
      ph_sat = PHMAX;
    end else if (ph < -PHMAX) begin
      ph_sat = -PHMAX;
    end
  end

  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      plo_q    <= LPW'(xc[SPLIT-1:0]) * LPW'(INV_GAIN_Q30);
      phi_q    <= HPW'(xc[XU-1:SPLIT]) * HPW'(INV_GAIN_Q30);
      pha_q    <= vec_i.zero ? '0 : ph_sat[PHASE_WIDTH-1:0];
      zero_a_q <= vec_i.zero;
    end
  end

  always_comb begin
    sum      = (SW'(phi_q) << SPLIT) + SW'(plo_q) + MRND;
    mag_full = sum >> MSH;
  end

  assign en_b = !vb_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      if (zero_a_q) begin
        mag_q <= '0;
      end else if (mag_full > MAGMAX) begin
        mag_q <= {DATA_WIDTH{1'b1}};
      end else begin
        mag_q <= mag_full[DATA_WIDTH-1:0];
      end
      phb_q <= pha_q;
    end
  end

  assign valid_o     = vb_q;
  assign magnitude_o = mag_q;
  assign phase_o     = phb_q;

endmodule
`default_nettype wire

// ===== rtl/core/cartesian_to_polar_top.sv =====
// Top level of the streaming CORDIC Cartesian-to-polar converter.
// Converts one complex coefficient (real_part_i, imag_part_i) per transaction into its
// gain-corrected magnitude and its phase atan2(im, re) in radians, signed with
// PHASE_WIDTH-3 fraction bits; an all-zero input yields zero magnitude and phase.
// The datapath is a chain of cells, each holding one registered step: a fold cell
// that moves the vector into the right half plane, CORDIC_STAGES micro-rotation cells,
// and two output cells for the split gain multiply and the rounding. It takes one
// transaction per clock when the output side does not stall. Every cell holds its
// transaction while the next one is full and stalled, so bubbles close up and input
// is refused only when all cells hold data and the output is not taken.
`default_nettype none
module cartesian_to_polar_top import c2p_pkg::*; #(
  parameter int unsigned DATA_WIDTH    = DATA_WIDTH_DEF,
  parameter int unsigned PHASE_WIDTH   = PHASE_WIDTH_DEF,
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [DATA_WIDTH-1:0]  real_part_i,
  input  wire logic signed [DATA_WIDTH-1:0]  imag_part_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [DATA_WIDTH-1:0]              magnitude_o,
  output logic signed [PHASE_WIDTH-1:0]      phase_o
);

  c2p_vec_t                 vec   [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0]   valid;
  logic [CORDIC_STAGES:0]   ready;

  c2p_fold #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .valid_o     (valid[0]),
    .ready_i     (ready[0]),
    .vec_o       (vec[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    c2p_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .ready_o (ready[i]),
      .vec_i   (vec[i]),
      .valid_o (valid[i+1]),
      .ready_i (ready[i+1]),
      .vec_o   (vec[i+1])
    );
  end

  c2p_scale #(
    .DATA_WIDTH  (DATA_WIDTH),
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid[CORDIC_STAGES]),
    .ready_o     (ready[CORDIC_STAGES]),
    .vec_i       (vec[CORDIC_STAGES]),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .magnitude_o (magnitude_o),
    .phase_o     (phase_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/c2p_checker.sv =====
// Port-level assertions for the polar converter, bound to the top level.
`default_nettype none
module c2p_checker import c2p_pkg::*; #(
  parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int unsigned PHASE_WIDTH = PHASE_WIDTH_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [DATA_WIDTH-1:0]         magnitude_o,
  input wire logic signed [PHASE_WIDTH-1:0] phase_o
);

  localparam int unsigned PS = ANG_FRAC - (PHASE_WIDTH - 3);
  localparam logic signed [PHASE_WIDTH-1:0] PHMAX =
    PHASE_WIDTH'((PI_Q30 + (64'd1 << (PS - 1))) >> PS);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(magnitude_o) && $stable(phase_o))
    else $error("result payload changed while stalled");

  a_no_false_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused while output side is free");

  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (phase_o <= PHMAX) && (phase_o >= -PHMAX))
    else $error("phase outside -pi to pi");

endmodule

bind cartesian_to_polar_top c2p_checker #(
  .DATA_WIDTH  (DATA_WIDTH),
  .PHASE_WIDTH (PHASE_WIDTH)
) u_c2p_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .magnitude_o (magnitude_o),
  .phase_o     (phase_o)
);
`default_nettype wire

// ===== dv/cartesian_to_polar_top_tb.sv =====
// Self-checking testbench for the CORDIC Cartesian-to-polar converter.
`default_nettype none
module cartesian_to_polar_top_tb;
  import c2p_pkg::*;

  localparam int DW          = DATA_WIDTH_DEF;
  localparam int PW          = PHASE_WIDTH_DEF;
  localparam int NS          = CORDIC_STAGES_DEF;
  localparam int GUARD_BITS  = 32 - DW;
  localparam int PH_SHIFT    = ANG_FRAC - (PW - 3);
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS  = 50;

  localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
  } coef_t;

  typedef struct packed {
    logic [DW-1:0]        mag;
    logic signed [PW-1:0] phase;
  } polar_t;

  typedef struct packed {
    coef_t  src;
    polar_t res;
  } pending_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DW-1:0] real_d = '0;
  logic signed [DW-1:0] imag_d = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DW-1:0] mag;
  logic signed [PW-1:0] ph;
  logic in_acc = 1'b0;

  coef_t           coef_queue[$];
  pending_result_t polar_expected[$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int n_in = 0;
  int n_out = 0;

  cartesian_to_polar_top #(
    .DATA_WIDTH    (DW),
    .PHASE_WIDTH   (PW),
    .CORDIC_STAGES (NS)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .real_part_i (real_d),
    .imag_part_i (imag_d),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .magnitude_o (mag),
    .phase_o     (ph)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint atan_step(input int idx);
    case (idx)
      0:       return 843314857;
      1:       return 497837829;
      2:       return 263043837;
      3:       return 133525159;
      4:       return 67021687;
      5:       return 33543516;
      6:       return 16775851;
      7:       return 8388437;
      8:       return 4194283;
      9:       return 2097149;
      10:      return 1048576;
      11:      return 524288;
      12:      return 262144;
      13:      return 131072;
      14:      return 65536;
      15:      return 32768;
      16:      return 16384;
      17:      return 8192;
      18:      return 4096;
      19:      return 2048;
      20:      return 1024;
      21:      return 512;
      22:      return 256;
      23:      return 128;
      default: return 0;
    endcase
  endfunction

  // vectoring CORDIC: fold into right half plane, rotate y to zero, scale x by 1/K
  function automatic polar_t polar_of(input logic signed [DW-1:0] re_v,
                                      input logic signed [DW-1:0] im_v);
    longint x, y, z, t, dx, dy, ph_v, ph_lim;
    longint unsigned xu, m;
    polar_t r;
    r = '0;
    if (re_v == 0 && im_v == 0) return r;
    x = re_v;
    y = im_v;
    x = x <<< GUARD_BITS;
    y = y <<< GUARD_BITS;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = HALF_PI_Q30;
      end else begin
        x = -y;
        y = t;
        z = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < NS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step(i);
      end
    end
    if (x < 0) x = 0;
    xu = x;
    m = (xu * INV_GAIN_Q30 + (64'd1 << (ANG_FRAC + GUARD_BITS - 1)))
        >> (ANG_FRAC + GUARD_BITS);
    if (m > (64'd1 << DW) - 64'd1) m = (64'd1 << DW) - 64'd1;
    ph_lim = PI_Q30;
    ph_lim = (ph_lim + (64'sd1 <<< (PH_SHIFT - 1))) >>> PH_SHIFT;
    ph_v = (z + (64'sd1 <<< (PH_SHIFT - 1))) >>> PH_SHIFT;
    if (ph_v > ph_lim) ph_v = ph_lim;
    if (ph_v < -ph_lim) ph_v = -ph_lim;
    r.mag = m[DW-1:0];
    r.phase = ph_v[PW-1:0];
    return r;
  endfunction

  function automatic coef_t rand_coef();
    logic [31:0] a, b;
    coef_t c;
    a = $urandom;
    b = $urandom;
    c.re = a[DW-1:0];
    c.im = b[DW-1:0];
    case ($urandom_range(0, 9))
      0: begin
        a = $urandom_range(0, 32) - 16;
        b = $urandom_range(0, 32) - 16;
        c.re = a[DW-1:0];
        c.im = b[DW-1:0];
      end
      1: begin
        if ($urandom_range(0, 1) == 1) c.im = '0;
        else c.re = '0;
      end
      2: c.im = ($urandom_range(0, 1) == 1) ? c.re : -c.re;
      3: begin
        c.re = ($urandom_range(0, 1) == 1) ? MAX_V : MIN_V;
        if ($urandom_range(0, 1) == 1) c.im = ($urandom_range(0, 1) == 1) ? MAX_V : MIN_V;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic add_coef(input logic signed [DW-1:0] re_v, input logic signed [DW-1:0] im_v);
    coef_t c;
    c.re = re_v;
    c.im = im_v;
    coef_queue.push_back(c);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // wait until every queued transaction has been accepted
  task automatic wait_sent();
    while (coef_queue.size() != 0 || in_valid) @(posedge clk);
  endtask

  // wait until every expected result has been checked; returns at a rising edge
  task automatic wait_drained();
    while (polar_expected.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin : drive_in
    coef_t nxt;
    if (rst_n && (!in_valid || in_acc)) begin
      if (coef_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nxt = coef_queue.pop_front();
        real_d <= nxt.re;
        imag_d <= nxt.im;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  // monitor: results are checked before new inputs are recorded
  always @(posedge clk) begin : monitor
    pending_result_t want;
    in_acc <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      n_out++;
      if (polar_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result: magnitude %0d phase %0d", mag, ph));
      end else begin
        want = polar_expected.pop_front();
        if (mag !== want.res.mag)
          report_mismatch($sformatf("re %0d im %0d: magnitude %0d, expected %0d",
                                    want.src.re, want.src.im, mag, want.res.mag));
        if (ph !== want.res.phase)
          report_mismatch($sformatf("re %0d im %0d: phase %0d, expected %0d",
                                    want.src.re, want.src.im, ph, want.res.phase));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      n_in++;
      want.src.re = real_d;
      want.src.im = imag_d;
      want.res = polar_of(real_d, imag_d);
      polar_expected.push_back(want);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // no idling; directed corners, then random behind a long output hold-off
    src_idle_pct = 0;
    snk_stall_pct = 0;
    add_coef('0, '0);
    add_coef(1, 0);
    add_coef(0, 1);
    add_coef(-1, 0);
    add_coef(0, -1);
    add_coef(MAX_V, 0);
    add_coef(MIN_V, 0);
    add_coef(0, MAX_V);
    add_coef(0, MIN_V);
    add_coef(MAX_V, MAX_V);
    add_coef(MIN_V, MIN_V);
    add_coef(MAX_V, MIN_V);
    add_coef(MIN_V, MAX_V);
    add_coef(1, 1);
    add_coef(-1, -1);
    add_coef(-5, 3);
    add_coef(-5, -3);
    add_coef(7, -2);
    add_coef(MIN_V, 1);
    add_coef(MIN_V, -1);
    add_coef(3, -4);
    add_coef(12345, 6789);
    repeat (275) coef_queue.push_back(rand_coef());
    hold_req = hold_req + 1;
    wait_sent();
    wait_drained();

    src_idle_pct = 53;
    snk_stall_pct = 0;
    repeat (350) coef_queue.push_back(rand_coef());
    wait_sent();
    wait_drained();

    src_idle_pct = 0;
    snk_stall_pct = 53;
    repeat (350) coef_queue.push_back(rand_coef());
    wait_sent();
    wait_drained();

    src_idle_pct = 16;
    snk_stall_pct = 16;
    repeat (350) coef_queue.push_back(rand_coef());
    wait_sent();
    wait_drained();

    repeat (NS + 10) @(posedge clk);
    $display("coefficients sent: %0d, polar results checked: %0d, bad fields: %0d",
             n_in, n_out, mismatches);
    $display("idle mixes: none, sender 53%%, receiver 53%%, both 16%%; one long output hold-off");
    if (mismatches == 0 && polar_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
